@@ src/lmcfb_pkg.sv @@
// Shared types and constants for the LED matrix chain frame builder.
// No dependencies; used by lmcfb_word and led_matrix_chain_frame_builder_top.
`timescale 1ns / 1ps

package lmcfb_pkg;

    // Longest chain that one frame covers, in words.
    localparam int MAX_CHAIN = 8;

    localparam int CHAIN_LEN_W = 4;
    localparam int SLOT_W      = 3;
    localparam int COLUMN_W    = 6;
    localparam int ROW_W       = 3;
    localparam int BYTE_W      = 8;

    localparam logic [CHAIN_LEN_W-1:0] CHAIN_LEN_RESET = CHAIN_LEN_W'(1);
    localparam logic [CHAIN_LEN_W-1:0] CHAIN_LEN_MAX   = CHAIN_LEN_W'(MAX_CHAIN);

    typedef enum logic [2:0] {
        MODE_CMD_ALL = 3'd0,
        MODE_CMD_ONE = 3'd1,
        MODE_COL     = 3'd2,
        MODE_COL_ALL = 3'd3,
        MODE_DOT     = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0]          mode;
        logic [SLOT_W-1:0]   target_slot;
        logic [BYTE_W-1:0]   command_byte;
        logic [COLUMN_W-1:0] column_index;
        logic [ROW_W-1:0]    row_index;
        logic [BYTE_W-1:0]   data_byte;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] reg_address;
        logic [BYTE_W-1:0] reg_data;
    } t_word;

endpackage

@@ src/led_matrix_chain_frame_builder_top.sv @@
// A request is held in the request register, and each of its words is then registered
// in the output stage. A request yields min(chain_length, 8) words, one word per cycle
// while the output is not stalled, set by the slot counter stepping the request
// register; a new request is taken in the cycle the last word leaves that register, so
// frames follow back to back. Chain length zero: the request is taken, produces no words.
// Reset (synchronous, active low) empties both stages and sets chain_length to 1.
`timescale 1ns / 1ps

module led_matrix_chain_frame_builder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [lmcfb_pkg::CHAIN_LEN_W-1:0] i_cfg_wr_data,
    // request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: target_slot[2:0], command_byte[10:3], column_index[16:11],
    //        row_index[19:17], data_byte[27:20], zero[31:28]
    input  logic [31:0]                      i_s_tdata,
    // tuser: mode[2:0]
    input  logic [2:0]                       i_s_tuser,
    // word stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: slot_position[2:0], reg_address[10:3], reg_data[18:11], zero[23:19]
    output logic [23:0]                      o_m_tdata,
    output logic                             o_m_tlast
);

    logic [lmcfb_pkg::CHAIN_LEN_W-1:0] r_chain_len;

    logic                              r_in_valid;
    lmcfb_pkg::t_req                   r_req;
    logic [lmcfb_pkg::SLOT_W-1:0]      r_idx;
    logic [lmcfb_pkg::SLOT_W-1:0]      r_last_idx;

    logic                              r_out_valid;
    logic [lmcfb_pkg::SLOT_W-1:0]      r_out_slot;
    lmcfb_pkg::t_word                  r_out_word;
    logic                              r_out_last;

    lmcfb_pkg::t_req                   w_s_req;
    lmcfb_pkg::t_word                  w_word;
    logic [lmcfb_pkg::CHAIN_LEN_W-1:0] w_words;
    logic                              w_out_ready;
    logic                              w_emit;
    logic                              w_last;
    logic                              w_s_fire;
    logic [lmcfb_pkg::SLOT_W-1:0]      n_idx;

    assign w_s_req.mode         = i_s_tuser;
    assign w_s_req.target_slot  = i_s_tdata[2:0];
    assign w_s_req.command_byte = i_s_tdata[10:3];
    assign w_s_req.column_index = i_s_tdata[16:11];
    assign w_s_req.row_index    = i_s_tdata[19:17];
    assign w_s_req.data_byte    = i_s_tdata[27:20];

    // Clamp the chain length to the longest supported chain.
    assign w_words = (r_chain_len > lmcfb_pkg::CHAIN_LEN_MAX) ?
                     lmcfb_pkg::CHAIN_LEN_MAX : r_chain_len;

    assign w_out_ready = !r_out_valid || i_m_tready;
    assign w_emit      = r_in_valid && w_out_ready;
    assign w_last      = (r_idx == r_last_idx);
    assign o_s_tready  = !r_in_valid || (w_emit && w_last);
    assign w_s_fire    = i_s_tvalid && o_s_tready;
    assign n_idx       = r_idx + 3'd1;

    lmcfb_word u_word (
        .i_req  (r_req),
        .i_slot (r_idx),
        .o_word (w_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_len <= lmcfb_pkg::CHAIN_LEN_RESET;
            r_in_valid  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_chain_len <= i_cfg_wr_data;
            end

            // Drop a request at once when the chain is empty.
            if (w_s_fire) begin
                r_in_valid <= (w_words != '0);
                r_idx      <= '0;
            end else if (w_emit) begin
                if (w_last) begin
                    r_in_valid <= 1'b0;
                end else begin
                    r_idx <= n_idx;
                end
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_req      <= w_s_req;
            r_last_idx <= lmcfb_pkg::SLOT_W'(w_words - 4'd1);
        end
        if (w_emit) begin
            r_out_slot <= r_idx;
            r_out_word <= w_word;
            r_out_last <= w_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_word.reg_data, r_out_word.reg_address, r_out_slot};
    assign o_m_tlast  = r_out_last;

endmodule

@@ src/lmcfb_word.sv @@
// Word formation for one chain slot: register address and data for a request.
// Depends on lmcfb_pkg.
`timescale 1ns / 1ps

module lmcfb_word (
    input  lmcfb_pkg::t_req                  i_req,
    input  logic [lmcfb_pkg::SLOT_W-1:0]     i_slot,
    output lmcfb_pkg::t_word                 o_word
);

    logic [lmcfb_pkg::SLOT_W-1:0] w_sel_slot;
    logic [lmcfb_pkg::BYTE_W-1:0] w_local_addr;
    logic [lmcfb_pkg::BYTE_W-1:0] w_col_all_addr;
    logic [lmcfb_pkg::BYTE_W-1:0] w_dot;

    // Global column splits into slot (upper bits) and local column (lower bits).
    assign w_sel_slot     = i_req.column_index[lmcfb_pkg::COLUMN_W-1:3];
    assign w_local_addr   = lmcfb_pkg::BYTE_W'(i_req.column_index[2:0]) + 8'd1;
    assign w_col_all_addr = lmcfb_pkg::BYTE_W'(i_req.column_index) + 8'd1;
    assign w_dot          = (i_req.data_byte != '0) ?
                            (8'd1 << i_req.row_index) : '0;

    always_comb begin
        o_word = '0;
        case (lmcfb_pkg::t_mode'(i_req.mode))
            lmcfb_pkg::MODE_CMD_ALL: begin
                o_word.reg_address = i_req.command_byte;
                o_word.reg_data    = i_req.data_byte;
            end
            lmcfb_pkg::MODE_CMD_ONE: begin
                if (i_slot == i_req.target_slot) begin
                    o_word.reg_address = i_req.command_byte;
                    o_word.reg_data    = i_req.data_byte;
                end
            end
            lmcfb_pkg::MODE_COL: begin
                if (i_slot == w_sel_slot) begin
                    o_word.reg_address = w_local_addr;
                    o_word.reg_data    = i_req.data_byte;
                end
            end
            lmcfb_pkg::MODE_COL_ALL: begin
                o_word.reg_address = w_col_all_addr;
                o_word.reg_data    = i_req.data_byte;
            end
            lmcfb_pkg::MODE_DOT: begin
                if (i_slot == w_sel_slot) begin
                    o_word.reg_address = w_local_addr;
                    o_word.reg_data    = w_dot;
                end
            end
            default: begin
                // Unused mode codes: no-op on every slot.
                o_word = '0;
            end
        endcase
    end

endmodule

@@ tb/sv/tb_led_matrix_chain_frame_builder_top.sv @@
// Self-checking testbench for led_matrix_chain_frame_builder_top: streams display requests,
// predicts every chain word and compares each word transaction against the prediction.
// Depends on lmcfb_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_led_matrix_chain_frame_builder_top;

    import lmcfb_pkg::*;

    localparam int          CLK_HALF_NS  = 4;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RESET_CYCLES = 9;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          REPORT_CAP   = 40;
    localparam int          CHUNK_ITEMS  = 25;
    localparam int          NUM_CHUNKS   = 12;
    localparam int          NUM_DIRECTED = 24;

    // Mode codes the block does not define; frames still go out with no-ops.
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0] slot;
        logic [7:0] addr;
        logic [7:0] data;
        logic       last;
    } frame_word_t;

    typedef struct {
        bit         is_cfg;
        logic [3:0] chain_len;
        logic [2:0] mode;
        logic [2:0] target;
        logic [7:0] cmd;
        logic [5:0] col;
        logic [2:0] row;
        logic [7:0] dat;
        bit         typed;
        logic [7:0] exp_addr;
        logic [7:0] exp_data;
    } stim_row_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [3:0]  i_cfg_wr_data = '0;
    logic        i_s_tvalid    = 1'b0;
    logic [31:0] i_s_tdata     = '0;
    logic [2:0]  i_s_tuser     = '0;
    logic        i_m_tready    = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast;

    frame_word_t pending_words[$];
    logic [3:0]  chain_len_shadow = CHAIN_LEN_RESET;
    int          mismatch_count   = 0;
    int unsigned cycle_count      = 0;
    int          gap_pct          = 0;
    int          stall_pct        = 0;

    int gap_by_phase   [4] = '{0, 67, 0, 23};
    int stall_by_phase [4] = '{0, 0, 67, 23};
    logic [3:0] chain_by_chunk [NUM_CHUNKS] =
        '{4'd8, 4'd0, 4'd3, 4'd15, 4'd1, 4'd5, 4'd8, 4'd2, 4'd9, 4'd7, 4'd4, 4'd6};

    // Rows at the reset chain length of one carry their single word inline.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{0, 4'd0,  MODE_CMD_ALL, 3'd0, 8'hFF, 6'd0,  3'd0, 8'hFF, 1, 8'hFF, 8'hFF},
        '{0, 4'd0,  MODE_CMD_ALL, 3'd0, 8'h00, 6'd0,  3'd0, 8'h00, 1, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_CMD_ONE, 3'd0, 8'h0C, 6'd0,  3'd0, 8'h01, 1, 8'h0C, 8'h01},
        '{0, 4'd0,  MODE_CMD_ONE, 3'd7, 8'h0A, 6'd0,  3'd0, 8'h0F, 1, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_COL,     3'd0, 8'h00, 6'd0,  3'd0, 8'hA5, 1, 8'h01, 8'hA5},
        '{0, 4'd0,  MODE_COL,     3'd0, 8'h00, 6'd63, 3'd0, 8'hFF, 1, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_COL_ALL, 3'd0, 8'h00, 6'd7,  3'd0, 8'h3C, 1, 8'h08, 8'h3C},
        '{0, 4'd0,  MODE_COL_ALL, 3'd0, 8'h00, 6'd63, 3'd0, 8'h81, 1, 8'h40, 8'h81},
        '{0, 4'd0,  MODE_DOT,     3'd0, 8'h00, 6'd0,  3'd7, 8'h01, 1, 8'h01, 8'h80},
        '{0, 4'd0,  MODE_DOT,     3'd0, 8'h00, 6'd5,  3'd0, 8'h00, 1, 8'h06, 8'h00},
        '{0, 4'd0,  MODE_SPARE_7, 3'd7, 8'hFF, 6'd63, 3'd7, 8'hFF, 1, 8'h00, 8'h00},
        '{1, 4'd8,  MODE_CMD_ALL, 3'd0, 8'h00, 6'd0,  3'd0, 8'h00, 0, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_CMD_ONE, 3'd7, 8'hFF, 6'd0,  3'd0, 8'h55, 0, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_COL,     3'd0, 8'h00, 6'd63, 3'd0, 8'hFF, 0, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_DOT,     3'd0, 8'h00, 6'd60, 3'd3, 8'hFF, 0, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_COL_ALL, 3'd0, 8'h00, 6'd0,  3'd0, 8'h00, 0, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_SPARE_5, 3'd2, 8'h12, 6'd9,  3'd1, 8'h34, 0, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_SPARE_6, 3'd5, 8'hAB, 6'd40, 3'd6, 8'hCD, 0, 8'h00, 8'h00},
        '{1, 4'd0,  MODE_CMD_ALL, 3'd0, 8'h00, 6'd0,  3'd0, 8'h00, 0, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_CMD_ALL, 3'd0, 8'hFF, 6'd0,  3'd0, 8'hFF, 0, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_DOT,     3'd0, 8'h00, 6'd0,  3'd0, 8'h01, 0, 8'h00, 8'h00},
        '{1, 4'd15, MODE_CMD_ALL, 3'd0, 8'h00, 6'd0,  3'd0, 8'h00, 0, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_CMD_ALL, 3'd0, 8'h0B, 6'd0,  3'd0, 8'h07, 0, 8'h00, 8'h00},
        '{0, 4'd0,  MODE_CMD_ONE, 3'd3, 8'h01, 6'd0,  3'd0, 8'h02, 0, 8'h00, 8'h00}
    };

    led_matrix_chain_frame_builder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

    initial begin
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // Queue the words one request produces at the current chain length.
    function automatic void build_expected_frame(input logic [3:0] chain_len,
                                                 input logic [2:0] mode,
                                                 input logic [2:0] target,
                                                 input logic [7:0] cmd,
                                                 input logic [5:0] col,
                                                 input logic [2:0] row,
                                                 input logic [7:0] dat);
        int unsigned words;
        int unsigned sel_slot;
        logic [7:0]  local_addr;
        frame_word_t w;
        words      = (chain_len > MAX_CHAIN) ? MAX_CHAIN : chain_len;
        sel_slot   = col[5:3];
        local_addr = {5'd0, col[2:0]} + 8'd1;
        for (int unsigned i = 0; i < words; i++) begin
            w.slot = i[2:0];
            w.addr = '0;
            w.data = '0;
            w.last = (i + 1 == words);
            case (mode)
                MODE_CMD_ALL: begin
                    w.addr = cmd;
                    w.data = dat;
                end
                MODE_CMD_ONE: if (i == target) begin
                    w.addr = cmd;
                    w.data = dat;
                end
                MODE_COL: if (i == sel_slot) begin
                    w.addr = local_addr;
                    w.data = dat;
                end
                MODE_COL_ALL: begin
                    w.addr = {2'd0, col} + 8'd1;
                    w.data = dat;
                end
                MODE_DOT: if (i == sel_slot) begin
                    w.addr = local_addr;
                    w.data = (dat != 8'd0) ? (8'd1 << row) : 8'd0;
                end
                default: ;
            endcase
            pending_words.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        if (mismatch_count < REPORT_CAP) begin
            $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp_val);
        end
        mismatch_count++;
    endtask

    task automatic wait_frames_done();
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // Write chain_length only once the chain is quiet.
    task automatic write_chain_length(input logic [3:0] value);
        i_s_tvalid <= 1'b0;
        wait_frames_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en      <= 1'b0;
        chain_len_shadow  = value;
    endtask

    task automatic send_request(input logic [2:0] mode, input logic [2:0] target,
                                input logic [7:0] cmd, input logic [5:0] col,
                                input logic [2:0] row, input logic [7:0] dat,
                                input bit typed, input logic [7:0] exp_addr,
                                input logic [7:0] exp_data);
        frame_word_t w;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, dat, row, col, cmd, target};
        i_s_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (typed) begin
            w = '{slot: 3'd0, addr: exp_addr, data: exp_data, last: 1'b1};
            pending_words.push_back(w);
        end else begin
            build_expected_frame(chain_len_shadow, mode, target, cmd, col, row, dat);
        end
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check each word transaction against the oldest prediction.
    always @(posedge i_clk) begin
        frame_word_t exp_w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word, address", o_m_tdata[10:3], 8'd0);
            end else begin
                exp_w = pending_words.pop_front();
                if (o_m_tdata[2:0] !== exp_w.slot)
                    report_mismatch("slot_position", {5'd0, o_m_tdata[2:0]}, {5'd0, exp_w.slot});
                if (o_m_tdata[10:3] !== exp_w.addr)
                    report_mismatch("reg_address", o_m_tdata[10:3], exp_w.addr);
                if (o_m_tdata[18:11] !== exp_w.data)
                    report_mismatch("reg_data", o_m_tdata[18:11], exp_w.data);
                if (o_m_tlast !== exp_w.last)
                    report_mismatch("last_word", {7'd0, o_m_tlast}, {7'd0, exp_w.last});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int unsigned span;
        logic [2:0]  mode;
        logic [2:0]  target;
        logic [5:0]  col;
        logic [7:0]  dat;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                write_chain_length(directed_rows[k].chain_len);
            end else begin
                send_request(directed_rows[k].mode, directed_rows[k].target,
                             directed_rows[k].cmd, directed_rows[k].col,
                             directed_rows[k].row, directed_rows[k].dat,
                             directed_rows[k].typed, directed_rows[k].exp_addr,
                             directed_rows[k].exp_data);
            end
        end

        for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
            write_chain_length(chain_by_chunk[chunk]);
            gap_pct   = gap_by_phase[chunk / 3];
            stall_pct = stall_by_phase[chunk / 3];
            span = (chain_len_shadow == 0) ? 1 :
                   (chain_len_shadow > MAX_CHAIN) ? MAX_CHAIN : chain_len_shadow;
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                // hold off mid-chunk until the chain has drained
                if (n == CHUNK_ITEMS / 2) begin
                    i_s_tvalid <= 1'b0;
                    wait_frames_done();
                end
                mode = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 4))
                                                    : 3'($urandom_range(5, 7));
                // aim most addressed slots inside the chain
                target = ($urandom_range(0, 1) != 0) ? 3'($urandom_range(0, span - 1))
                                                     : 3'($urandom_range(0, 7));
                if (mode == MODE_COL_ALL)
                    col = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7))
                                                      : 6'($urandom_range(0, 63));
                else
                    col = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 8 * span - 1))
                                                      : 6'($urandom_range(0, 63));
                dat = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
                send_request(mode, target, 8'($urandom_range(0, 255)), col,
                             3'($urandom_range(0, 7)), dat, 1'b0, 8'd0, 8'd0);
            end
        end

        i_s_tvalid <= 1'b0;
        wait_frames_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/lmcfb_pkg.sv
src/lmcfb_word.sv
src/led_matrix_chain_frame_builder_top.sv
tb/sv/tb_led_matrix_chain_frame_builder_top.sv
